>>> hw/rtl/qte_pkg.sv
// shared constants, types and the arctangent table for the quaternion to euler block
package qte_pkg;

   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 7;

   // cordic operand and angle accumulator widths (q30 operands, q30 radians)
   localparam int OPW = 40;
   localparam int ZW  = 35;

   // integer square root: 31 two-bit steps over a 61-bit radicand
   localparam int SQ_STEPS = 31;
   localparam int VW       = 61;
   localparam int RW       = 62;

   // radians to degree field conversion
   localparam int MAGW        = ZW - 1;
   localparam int MW          = MAGW + 10;
   localparam int TW          = MW + ANGLE_FRAC_BITS + 1;
   localparam int UW          = TW - 31;
   localparam int QW          = UW;
   localparam int RECIP_SHIFT = 28;
   localparam int PW          = UW + RECIP_SHIFT;

   localparam logic [RECIP_SHIFT-1:0] RECIP_FIVE = RECIP_SHIFT'(53687091);
   localparam logic [9:0]             DEG_SCALE  = 10'd573;
   localparam logic [TW-1:0]          HALF_DEN   = TW'(64'd5368709120);
   localparam logic signed [ZW-1:0]   PI_Q30     = ZW'(64'sd3373259426);

   localparam int LANE_LAT = CORDIC_STEPS + 4;
   localparam int PIPE_LEN = 34 + LANE_LAT;

   localparam int PITCH_W = 15;
   localparam int ANG_W   = 16;

   localparam int MIDQ_DEPTH = 4;
   localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
   localparam int OUTQ_DEPTH = 2;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

   typedef struct packed {
      logic signed [31:0] w;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ANG_W-1:0]   roll;
      logic signed [ANG_W-1:0]   yaw;
      logic                      clamped;
   } result_type;

   // atan(2^-i) in q30 radians, rounded to nearest
   function automatic logic [31:0] atan_entry(input int idx);
      logic [31:0] r;
      case (idx)
         0:  r = 32'd843314857;
         1:  r = 32'd497837829;
         2:  r = 32'd263043837;
         3:  r = 32'd133525159;
         4:  r = 32'd67021687;
         5:  r = 32'd33543516;
         6:  r = 32'd16775851;
         7:  r = 32'd8388437;
         8:  r = 32'd4194283;
         9:  r = 32'd2097149;
         10: r = 32'd1048576;
         11: r = 32'd524288;
         12: r = 32'd262144;
         13: r = 32'd131072;
         14: r = 32'd65536;
         15: r = 32'd32768;
         16: r = 32'd16384;
         17: r = 32'd8192;
         18: r = 32'd4096;
         19: r = 32'd2048;
         20: r = 32'd1024;
         21: r = 32'd512;
         22: r = 32'd256;
         23: r = 32'd128;
         24: r = 32'd64;
         25: r = 32'd32;
         26: r = 32'd16;
         27: r = 32'd8;
         28: r = 32'd4;
         29: r = 32'd2;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/qte_front.sv
// front end: takes quaternion transactions, drops empty samples, queues the rest
module qte_front import qte_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [31:0] req_q_w,
   input  logic signed [31:0] req_q_x,
   input  logic signed [31:0] req_q_y,
   input  logic signed [31:0] req_q_z,
   input  logic               req_quat_present,
   output logic               q_valid,
   output quat_type           quat,
   input  logic               q_take
);

   quat_type                 mem_ff [0:MIDQ_DEPTH-1];
   logic [MIDQ_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [MIDQ_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [MIDQ_AW:0]         cnt_ff, cnt_in;
   logic                     wr;
   logic                     rd;

   assign full    = (cnt_ff == (MIDQ_AW+1)'(MIDQ_DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign quat    = mem_ff[rd_ptr_ff];

   // a sample without a quaternion is accepted and dropped here
   assign wr = push && !full && req_quat_present;
   assign rd = q_take && q_valid;

   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (MIDQ_AW+1)'(wr) - (MIDQ_AW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= '{w: req_q_w, x: req_q_x, y: req_q_y, z: req_q_z};
      end
   end

endmodule

>>> hw/rtl/qte_cordic.sv
// one pipelined vectoring cordic lane with conversion to degree units
module qte_cordic import qte_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [OPW-1:0] y_op,
   input  logic signed [OPW-1:0] x_op,
   output logic signed [QW-1:0]  angle
);

   logic signed [OPW-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [OPW-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [ZW-1:0]  z_ff [0:CORDIC_STEPS];
   logic                  zero_ff [0:CORDIC_STEPS];
   logic signed [OPW-1:0] x_in [0:CORDIC_STEPS];
   logic signed [OPW-1:0] y_in [0:CORDIC_STEPS];
   logic signed [ZW-1:0]  z_in [0:CORDIC_STEPS];
   logic                  zero_in [0:CORDIC_STEPS];

   logic signed [ZW-1:0]  zsel;
   logic                  neg;
   logic [MAGW-1:0]       mag;
   logic [MW-1:0]         m_ff, m_in;
   logic                  neg1_ff, neg2_ff;
   logic [TW-1:0]         t;
   logic [UW-1:0]         u_ff, u_in;
   logic [PW-1:0]         p_ff, p_in;
   logic [UW-1:0]         q0;
   logic [UW+2:0]         r;
   logic [UW-1:0]         q;
   logic signed [QW-1:0]  angle_ff, angle_in;

   // fold the left half plane onto the right one
   always_comb begin
      zero_in[0] = (x_op == '0) && (y_op == '0);
      if (x_op < 0) begin
         x_in[0] = -x_op;
         y_in[0] = -y_op;
         z_in[0] = (y_op >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
         x_in[0] = x_op;
         y_in[0] = y_op;
         z_in[0] = '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_entry(i));
      assign x_in[i+1] = y_ff[i][OPW-1] ? x_ff[i] - (y_ff[i] >>> i)
                                        : x_ff[i] + (y_ff[i] >>> i);
      assign y_in[i+1] = y_ff[i][OPW-1] ? y_ff[i] + (x_ff[i] >>> i)
                                        : y_ff[i] - (x_ff[i] >>> i);
      assign z_in[i+1] = y_ff[i][OPW-1] ? z_ff[i] - ATAN_I : z_ff[i] + ATAN_I;
      assign zero_in[i+1] = zero_ff[i];
   end

   // q30 radians times 573 * 2^frac / (10 * 2^30), rounded half away from zero
   always_comb begin
      zsel     = zero_ff[CORDIC_STEPS] ? '0 : z_ff[CORDIC_STEPS];
      neg      = zsel[ZW-1];
      mag      = neg ? MAGW'(-zsel) : MAGW'(zsel);
      m_in     = MW'(mag) * MW'(DEG_SCALE);
      t        = (TW'(m_ff) << ANGLE_FRAC_BITS) + HALF_DEN;
      u_in     = t[TW-1:31];
      p_in     = PW'(u_in) * PW'(RECIP_FIVE);
      q0       = p_ff[PW-1:RECIP_SHIFT];
      r        = (UW+3)'(u_ff) - (((UW+3)'(q0) << 2) + (UW+3)'(q0));
      q        = (r >= (UW+3)'(5)) ? q0 + 1'b1 : q0;
      angle_in = neg2_ff ? -$signed(q) : $signed(q);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            z_ff[k]    <= z_in[k];
            zero_ff[k] <= zero_in[k];
         end
         m_ff     <= m_in;
         neg1_ff  <= neg;
         u_ff     <= u_in;
         p_ff     <= p_in;
         neg2_ff  <= neg1_ff;
         angle_ff <= angle_in;
      end
   end

   // neg1 lines up with m, neg2 with u and p and is read with them
   assign angle = angle_ff;

endmodule

>>> hw/rtl/qte_back.sv
// back end: products, sums, pitch square root and three cordic lanes
module qte_back import qte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  quat_type   quat,
   output logic       in_take,
   output logic       out_valid,
   output result_type result,
   input  logic       out_full
);

   localparam logic signed [OPW-1:0] ONE_Q30 = OPW'(64'sd1073741824);

   logic                  en;
   logic                  vld_ff [0:PIPE_LEN-1];
   logic                  clamp_ff [1:PIPE_LEN-1];

   logic signed [33:0]    wy_ff, xz_ff, yz_ff, wx_ff, xx_ff, yy_ff, xy_ff, wz_ff;
   logic signed [33:0]    ww_ff, zz_ff;

   logic signed [OPW-1:0] s_raw;
   logic signed [31:0]    s_in;
   logic                  clamp_in;
   logic signed [31:0]    s1_ff;
   logic signed [OPW-1:0] ry1_ff, rx1_ff, py1_ff, px1_ff;

   logic [30:0]           abs_s;
   logic [61:0]           sq;

   logic [VW-1:0]         v_ff [0:SQ_STEPS];
   logic [RW-1:0]         r_ff [0:SQ_STEPS];
   logic [VW-1:0]         v_in [1:SQ_STEPS];
   logic [RW-1:0]         r_in [1:SQ_STEPS];
   logic signed [31:0]    s_d_ff  [0:SQ_STEPS];
   logic signed [OPW-1:0] ry_d_ff [0:SQ_STEPS];
   logic signed [OPW-1:0] rx_d_ff [0:SQ_STEPS];
   logic signed [OPW-1:0] py_d_ff [0:SQ_STEPS];
   logic signed [OPW-1:0] px_d_ff [0:SQ_STEPS];

   logic signed [QW-1:0]  pitch_q, roll_q, yaw_q;

   function automatic logic signed [33:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p[63:30];
   endfunction

   function automatic logic signed [ANG_W-1:0] sat16(input logic signed [QW-1:0] a);
      logic signed [ANG_W-1:0] r;
      if (a > QW'(2**(ANG_W-1)-1)) begin
         r = ANG_W'(2**(ANG_W-1)-1);
      end else if (a < -QW'(2**(ANG_W-1))) begin
         r = ANG_W'(-(2**(ANG_W-1)));
      end else begin
         r = ANG_W'(a);
      end
      return r;
   endfunction

   function automatic logic signed [PITCH_W-1:0] sat15(input logic signed [QW-1:0] a);
      logic signed [PITCH_W-1:0] r;
      if (a > QW'(2**(PITCH_W-1)-1)) begin
         r = PITCH_W'(2**(PITCH_W-1)-1);
      end else if (a < -QW'(2**(PITCH_W-1))) begin
         r = PITCH_W'(-(2**(PITCH_W-1)));
      end else begin
         r = PITCH_W'(a);
      end
      return r;
   endfunction

   // the whole pipe holds while a finished result cannot be handed on
   assign en      = !(vld_ff[PIPE_LEN-1] && out_full);
   assign in_take = en && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_LEN; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < PIPE_LEN; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // stage 0: q30 products
   always_ff @(posedge clock) begin
      if (en) begin
         wy_ff <= mulq(quat.w, quat.y);
         xz_ff <= mulq(quat.x, quat.z);
         yz_ff <= mulq(quat.y, quat.z);
         wx_ff <= mulq(quat.w, quat.x);
         xx_ff <= mulq(quat.x, quat.x);
         yy_ff <= mulq(quat.y, quat.y);
         xy_ff <= mulq(quat.x, quat.y);
         wz_ff <= mulq(quat.w, quat.z);
         ww_ff <= mulq(quat.w, quat.w);
         zz_ff <= mulq(quat.z, quat.z);
      end
   end

   // stage 1: sums and asin argument saturation
   always_comb begin
      s_raw = (OPW'(wy_ff) - OPW'(xz_ff)) <<< 1;
      if (s_raw > ONE_Q30) begin
         s_in     = 32'(ONE_Q30);
         clamp_in = 1'b1;
      end else if (s_raw < -ONE_Q30) begin
         s_in     = 32'(-ONE_Q30);
         clamp_in = 1'b1;
      end else begin
         s_in     = 32'(s_raw);
         clamp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= s_in;
         ry1_ff <= (OPW'(yz_ff) + OPW'(wx_ff)) <<< 1;
         rx1_ff <= ONE_Q30 - ((OPW'(xx_ff) + OPW'(yy_ff)) <<< 1);
         py1_ff <= (OPW'(xy_ff) + OPW'(wz_ff)) <<< 1;
         px1_ff <= OPW'(ww_ff) + OPW'(xx_ff) - OPW'(yy_ff) - OPW'(zz_ff);
         clamp_ff[1] <= clamp_in;
         for (int k = 2; k < PIPE_LEN; k++) begin
            clamp_ff[k] <= clamp_ff[k-1];
         end
      end
   end

   // stage 2: radicand 1 - s^2
   always_comb begin
      abs_s = s1_ff[31] ? 31'(-s1_ff) : 31'(s1_ff);
      sq    = 62'(abs_s) * 62'(abs_s);
   end

   // square root, two radicand bits per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam logic [RW-1:0] BIT_K = RW'(1) << (60 - 2 * k);
      logic [RW-1:0] trial;
      logic          ge;
      assign trial    = r_ff[k] + BIT_K;
      assign ge       = RW'(v_ff[k]) >= trial;
      assign v_in[k+1] = ge ? v_ff[k] - VW'(trial) : v_ff[k];
      assign r_in[k+1] = ge ? (r_ff[k] >> 1) + BIT_K : r_ff[k] >> 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0]    <= VW'(64'h1000_0000_0000_0000) - VW'(sq);
         r_ff[0]    <= '0;
         s_d_ff[0]  <= s1_ff;
         ry_d_ff[0] <= ry1_ff;
         rx_d_ff[0] <= rx1_ff;
         py_d_ff[0] <= py1_ff;
         px_d_ff[0] <= px1_ff;
         for (int k = 1; k <= SQ_STEPS; k++) begin
            v_ff[k]    <= v_in[k];
            r_ff[k]    <= r_in[k];
            s_d_ff[k]  <= s_d_ff[k-1];
            ry_d_ff[k] <= ry_d_ff[k-1];
            rx_d_ff[k] <= rx_d_ff[k-1];
            py_d_ff[k] <= py_d_ff[k-1];
            px_d_ff[k] <= px_d_ff[k-1];
         end
      end
   end

   qte_cordic u_pitch (
      .clock (clock),
      .en    (en),
      .y_op  (OPW'(s_d_ff[SQ_STEPS])),
      .x_op  ($signed(OPW'(r_ff[SQ_STEPS]))),
      .angle (pitch_q)
   );

   qte_cordic u_roll (
      .clock (clock),
      .en    (en),
      .y_op  (ry_d_ff[SQ_STEPS]),
      .x_op  (rx_d_ff[SQ_STEPS]),
      .angle (roll_q)
   );

   qte_cordic u_yaw (
      .clock (clock),
      .en    (en),
      .y_op  (py_d_ff[SQ_STEPS]),
      .x_op  (px_d_ff[SQ_STEPS]),
      .angle (yaw_q)
   );

   assign out_valid      = vld_ff[PIPE_LEN-1];
   assign result.pitch   = sat15(pitch_q);
   assign result.roll    = sat16(roll_q);
   assign result.yaw     = sat16(yaw_q);
   assign result.clamped = clamp_ff[PIPE_LEN-1];

endmodule

>>> hw/rtl/quaternion_to_euler_angles.sv
// Quaternion (q30) to ZYX euler angles in 1/128 degree. One transaction can enter every
// clock while the input queue is not full; a sample without a quaternion is consumed and
// gives no result. A result passes through the input queue, products, sums, the pitch
// square root (31 stages), the cordic lanes and degree conversion, then the result queue.
// The pipeline holds as a whole while a finished result waits and the 2-entry result
// queue is full; the 4-entry input queue absorbs that stall.
module quaternion_to_euler_angles import qte_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [31:0]        req_q_w,
   input  logic signed [31:0]        req_q_x,
   input  logic signed [31:0]        req_q_y,
   input  logic signed [31:0]        req_q_z,
   input  logic                      req_quat_present,
   output logic                      empty,
   input  logic                      pop,
   output logic signed [PITCH_W-1:0] rsp_pitch_angle,
   output logic signed [ANG_W-1:0]   rsp_roll_angle,
   output logic signed [ANG_W-1:0]   rsp_yaw_angle,
   output logic                      rsp_asin_clamped
);

   logic               q_valid;
   quat_type           quat;
   logic               q_take;
   logic               bk_valid;
   result_type         bk_result;
   logic               out_full;
   logic               out_wr;
   logic               out_rd;
   result_type         out_mem_ff [0:OUTQ_DEPTH-1];
   logic [OUTQ_AW-1:0] out_wp_ff, out_wp_in;
   logic [OUTQ_AW-1:0] out_rp_ff, out_rp_in;
   logic [OUTQ_AW:0]   out_cnt_ff, out_cnt_in;
   result_type         head;

   qte_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_q_w          (req_q_w),
      .req_q_x          (req_q_x),
      .req_q_y          (req_q_y),
      .req_q_z          (req_q_z),
      .req_quat_present (req_quat_present),
      .q_valid          (q_valid),
      .quat             (quat),
      .q_take           (q_take)
   );

   qte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .quat      (quat),
      .in_take   (q_take),
      .out_valid (bk_valid),
      .result    (bk_result),
      .out_full  (out_full)
   );

   // result queue
   assign out_full = (out_cnt_ff == (OUTQ_AW+1)'(OUTQ_DEPTH));
   assign out_wr   = bk_valid && !out_full;
   assign empty    = (out_cnt_ff == '0);
   assign out_rd   = pop && !empty;

   always_comb begin
      out_wp_in  = out_wr ? out_wp_ff + 1'b1 : out_wp_ff;
      out_rp_in  = out_rd ? out_rp_ff + 1'b1 : out_rp_ff;
      out_cnt_in = out_cnt_ff + (OUTQ_AW+1)'(out_wr) - (OUTQ_AW+1)'(out_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wp_ff  <= '0;
         out_rp_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         out_wp_ff  <= out_wp_in;
         out_rp_ff  <= out_rp_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_wr) begin
         out_mem_ff[out_wp_ff] <= bk_result;
      end
   end

   assign head             = out_mem_ff[out_rp_ff];
   assign rsp_pitch_angle  = head.pitch;
   assign rsp_roll_angle   = head.roll;
   assign rsp_yaw_angle    = head.yaw;
   assign rsp_asin_clamped = head.clamped;

`ifndef SYNTHESIS
   a_outq_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= (OUTQ_AW+1)'(OUTQ_DEPTH))
      else $error("result queue overflow");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (bk_valid && out_full && !out_rd) |=> bk_valid)
      else $error("stalled result lost in pipeline");

   a_last_drain: assert property (@(posedge clock) disable iff (reset)
      (out_rd && !out_wr && out_cnt_ff == (OUTQ_AW+1)'(1)) |=> empty)
      else $error("result queue not empty after last transaction popped");
`endif

endmodule
